FILE: src/moving_average_frame_rate_meter_defines.svh
// assertion helpers for the frame rate meter
`ifndef MOVING_AVERAGE_FRAME_RATE_METER_DEFINES_SVH
`define MOVING_AVERAGE_FRAME_RATE_METER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MAFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MAFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mafr_pkg.sv
`default_nettype none
package mafr_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int STAMP_BITS = 48;
  localparam int INTERVAL_W = 32;
  localparam int RATE_W     = 32;
  localparam int FRAC_BITS  = 8;
  localparam int WL_W       = 7;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int N_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = INTERVAL_W + PTR_W;
  localparam int PROD_W     = N_W + RATE_W;
  localparam int NUMER_W    = PROD_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(NUMER_W);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_TICK_RATE     = 1'b1;

  localparam logic [WL_W-1:0]   WL_RESET   = WL_W'(60);
  localparam logic [RATE_W-1:0] TICK_RESET = RATE_W'(1000);

  // one classified event between front and back
  typedef struct packed {
    logic                  frame;
    logic [INTERVAL_W-1:0] interval;
  } op_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [RATE_W-1:0] tick_rate;
    logic              clear;
  } cfg_t;

endpackage
`default_nettype wire

FILE: src/mafr_front.sv
`default_nettype none
module mafr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           command,
  input  wire logic [mafr_pkg::STAMP_BITS-1:0] timestamp,
  output logic                                push,
  output mafr_pkg::op_t                       push_op,
  input  wire logic                           q_full
);
  import mafr_pkg::*;

  logic [STAMP_BITS-1:0] previous_stamp;
  logic [STAMP_BITS-1:0] diff;
  logic                  accept;
  logic                  is_frame;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign diff     = timestamp - previous_stamp;
  assign is_frame = (command == CMD_FRAME) && (diff != '0);

  always_comb begin
    push_op.frame = is_frame;
    // saturate long gaps to the interval width
    if (64'(diff) > 64'({INTERVAL_W{1'b1}})) begin
      push_op.interval = {INTERVAL_W{1'b1}};
    end else begin
      push_op.interval = INTERVAL_W'(diff);
    end
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_stamp <= '0;
    end else if (accept && ((command == CMD_START) || is_frame)) begin
      previous_stamp <= timestamp;
    end
  end

endmodule
`default_nettype wire

FILE: src/mafr_queue.sv
`default_nettype none
module mafr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mafr_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output mafr_pkg::op_t      q_op
);
  import mafr_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_op    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/mafr_back.sv
`default_nettype none
module mafr_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mafr_pkg::cfg_t               cfg,
  input  wire logic                         q_valid,
  input  wire mafr_pkg::op_t                q_op,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mafr_pkg::RATE_W-1:0]       frame_rate,
  output logic                              rate_valid
);
  import mafr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state;
  logic [INTERVAL_W-1:0] win_mem [MAX_WINDOW];
  logic [INTERVAL_W-1:0] mem_q;
  logic [MAX_WINDOW-1:0] win_vld;
  logic [PTR_W-1:0]      ptr;
  logic [PTR_W-1:0]      slot;
  logic [PTR_W-1:0]      rd_addr;
  logic [INTERVAL_W-1:0] interval;
  logic [SUM_W-1:0]      interval_sum;
  logic [SUM_W-1:0]      sum_next;
  logic [INTERVAL_W-1:0] old_interval;
  logic [N_W-1:0]        slot_inc;
  logic [PTR_W-1:0]      ptr_next;
  logic [NUMER_W-1:0]    dq;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W:0]        rem_sh;
  logic                  ge;
  logic [SUM_W-1:0]      rem_next;
  logic [CNT_W-1:0]      cnt;
  logic                  mem_we;

  // slot that the next frame goes into
  assign rd_addr = (N_W'(ptr) >= cfg.n) ? '0 : ptr;
  assign pop     = (state == S_IDLE) && q_valid && !out_valid;
  assign mem_we  = (state == S_UPDATE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[slot] <= interval;
    end
    mem_q <= win_mem[rd_addr];
  end

  // unwritten slots read as zero
  assign old_interval = win_vld[slot] ? mem_q : '0;
  assign sum_next     = interval_sum - SUM_W'(old_interval) + SUM_W'(interval);
  assign slot_inc     = N_W'(slot) + N_W'(1);
  assign ptr_next     = (slot_inc >= cfg.n) ? '0 : PTR_W'(slot_inc);

  // one restoring division step per cycle
  assign rem_sh   = {rem, dq[NUMER_W-1]};
  assign ge       = (rem_sh >= {1'b0, interval_sum});
  assign rem_next = ge ? SUM_W'(rem_sh - {1'b0, interval_sum}) : SUM_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      win_vld      <= '0;
      ptr          <= '0;
      interval_sum <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg.clear) begin
        win_vld      <= '0;
        ptr          <= '0;
        interval_sum <= '0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_op.frame) begin
              slot     <= rd_addr;
              interval <= q_op.interval;
              state    <= S_UPDATE;
            end else begin
              out_valid  <= 1'b1;
              frame_rate <= '0;
              rate_valid <= 1'b0;
            end
          end
        end
        S_UPDATE: begin
          interval_sum  <= sum_next;
          win_vld[slot] <= 1'b1;
          ptr           <= ptr_next;
          // numerator n * tick_rate in Q.8
          dq            <= {PROD_W'(cfg.n) * PROD_W'(cfg.tick_rate), {FRAC_BITS{1'b0}}};
          rem           <= '0;
          cnt           <= '0;
          state         <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          dq  <= {dq[NUMER_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NUMER_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid  <= 1'b1;
          rate_valid <= 1'b1;
          if (|dq[NUMER_W-1:RATE_W]) begin
            frame_rate <= {RATE_W{1'b1}};
          end else begin
            frame_rate <= dq[RATE_W-1:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/moving_average_frame_rate_meter.sv
// a start or zero-interval beat passes the queue and is answered from the idle state;
//   a frame beat goes through the window update, then a 47-step serial divider
// the back end takes no new beat until its result has left; the divider makes one bit
//   per cycle, and a 2-entry queue lets input run ahead of the divider
// reset: synchronous; window_length 60, tick_rate 1000, window cleared at once
//   through per-slot valid bits, so no clearing pass is needed
`default_nettype none
module moving_average_frame_rate_meter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            command,
  input  wire logic [mafr_pkg::STAMP_BITS-1:0] timestamp,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mafr_pkg::RATE_W-1:0]          frame_rate,
  output logic                                 rate_valid
);
  import mafr_pkg::*;

  logic [WL_W-1:0]   window_length;
  logic [RATE_W-1:0] tick_rate;
  logic              wr_en;
  logic              push;
  op_t               push_op;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  op_t               q_op;
  cfg_t              cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      tick_rate     <= TICK_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WINDOW_LENGTH: window_length <= pwdata[WL_W-1:0];
        REG_TICK_RATE:     tick_rate     <= pwdata[RATE_W-1:0];
        default:           window_length <= window_length;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_LENGTH: prdata = 32'(window_length);
      REG_TICK_RATE:     prdata = 32'(tick_rate);
      default:           prdata = '0;
    endcase
  end

  // zero length acts as one, long lengths clamp to the store size
  always_comb begin
    if (window_length == '0) begin
      cfg.n = N_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      cfg.n = N_W'(MAX_WINDOW);
    end else begin
      cfg.n = N_W'(window_length);
    end
    cfg.tick_rate = tick_rate;
    cfg.clear     = wr_en && (paddr[2] == REG_WINDOW_LENGTH);
  end

  mafr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .timestamp (timestamp),
    .push      (push),
    .push_op   (push_op),
    .q_full    (q_full)
  );

  mafr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  mafr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_rate (frame_rate),
    .rate_valid (rate_valid)
  );

endmodule
`default_nettype wire

FILE: src/mafr_checker.sv
`default_nettype none
`include "moving_average_frame_rate_meter_defines.svh"
module mafr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [mafr_pkg::RATE_W-1:0]     frame_rate,
  input wire logic                            rate_valid
);
  import mafr_pkg::*;

  logic [3:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // beats accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   pending <= pending + 4'd1;
        2'b01:   pending <= pending - 4'd1;
        default: pending <= pending;
      endcase
    end
  end

  `MAFR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MAFR_ASSERT_NXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(frame_rate) && $stable(rate_valid), "result changed while stalled")
  `MAFR_ASSERT_IMP(a_zero_invalid, clk, rst, out_valid && !rate_valid, frame_rate == '0, "nonzero rate without rate_valid")
  `MAFR_ASSERT_IMP(a_no_extra, clk, rst, out_valid, pending != '0, "result without an accepted beat")

endmodule

bind moving_average_frame_rate_meter mafr_checker u_mafr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_rate (frame_rate),
  .rate_valid (rate_valid)
);
`default_nettype wire

FILE: verif/frame_rate_checker.sv
`default_nettype none
module frame_rate_checker
  import mafr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  command,
  input  wire logic [STAMP_BITS-1:0] timestamp,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [RATE_W-1:0]     frame_rate,
  input  wire logic                  rate_valid,
  output int                         fails,
  output int                         pending
);

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              valid;
  } meter_out_t;

  logic [WL_W-1:0]       cfg_window;
  logic [RATE_W-1:0]     cfg_ticks;
  logic [STAMP_BITS-1:0] last_stamp;
  logic [INTERVAL_W-1:0] slot_interval [MAX_WINDOW];
  int unsigned           slot_ptr;
  logic [SUM_W-1:0]      span_sum;
  meter_out_t            rate_q [$];

  function automatic void clear_window();
    foreach (slot_interval[i]) slot_interval[i] = '0;
    slot_ptr = 0;
    span_sum = '0;
  endfunction

  function automatic meter_out_t measure_rate(input logic cmd,
                                              input logic [STAMP_BITS-1:0] ts);
    meter_out_t            res;
    logic [STAMP_BITS-1:0] gap;
    logic [INTERVAL_W-1:0] span;
    int unsigned           n;
    logic [63:0]           numer;
    logic [63:0]           quot;
    res = '0;
    if (cmd == CMD_START) begin
      last_stamp = ts;
      return res;
    end
    gap = ts - last_stamp;
    if (gap == '0) return res;
    last_stamp = ts;
    span = (gap > 48'hFFFF_FFFF) ? '1 : gap[INTERVAL_W-1:0];
    n = (cfg_window == 0) ? 1 : ((cfg_window > MAX_WINDOW) ? MAX_WINDOW : cfg_window);
    if (slot_ptr >= n) slot_ptr = 0;
    span_sum = span_sum - SUM_W'(slot_interval[slot_ptr]) + SUM_W'(span);
    slot_interval[slot_ptr] = span;
    slot_ptr = (slot_ptr + 1 >= n) ? 0 : slot_ptr + 1;
    numer = 64'(n) * 64'(cfg_ticks) * 64'd256;
    quot = (span_sum != '0) ? numer / 64'(span_sum) : 64'd0;
    res.rate = (quot > 64'hFFFF_FFFF) ? '1 : quot[RATE_W-1:0];
    res.valid = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    meter_out_t want;
    if (rst) begin
      cfg_window = WL_RESET;
      cfg_ticks = TICK_RESET;
      last_stamp = '0;
      clear_window();
      rate_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW_LENGTH) begin
          cfg_window = pwdata[WL_W-1:0];
          clear_window();
        end else begin
          cfg_ticks = pwdata[RATE_W-1:0];
        end
      end
      // a result never leaves in the cycle of its own beat, so check before adding
      if (out_valid && !out_stall) begin
        if (rate_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got frame_rate %h rate_valid %b",
                   $time, frame_rate, rate_valid);
          fails++;
        end else begin
          want = rate_q[0];
          rate_q.delete(0);
          if (frame_rate !== want.rate) begin
            $display("%0t: frame_rate expected %h got %h", $time, want.rate, frame_rate);
            fails++;
          end
          if (rate_valid !== want.valid) begin
            $display("%0t: rate_valid expected %b got %b", $time, want.valid, rate_valid);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) rate_q.insert(rate_q.size(), measure_rate(command, timestamp));
    end
    pending = rate_q.size();
  end

endmodule
`default_nettype wire

FILE: verif/tb_moving_average_frame_rate_meter.sv
`default_nettype none
module tb_moving_average_frame_rate_meter;
  import mafr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic                  command;
  logic [STAMP_BITS-1:0] timestamp;
  logic                  out_valid;
  logic                  out_stall;
  logic [RATE_W-1:0]     frame_rate;
  logic                  rate_valid;
  int                    fails;
  int                    pending;
  int                    idle_cycles;
  bit                    quiet;
  int unsigned           gap_odds;

  moving_average_frame_rate_meter u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_rate(frame_rate), .rate_valid(rate_valid)
  );

  frame_rate_checker u_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_rate(frame_rate), .rate_valid(rate_valid),
    .fails(fails), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // output side backpressure: free stretches broken by stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [STAMP_BITS-1:0] rand_stamp();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic apb_write(input logic reg_idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // registers only change once the meter has drained
  task automatic set_meter(input logic [WL_W-1:0] window, input logic [RATE_W-1:0] ticks);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    apb_write(REG_WINDOW_LENGTH, 32'(window));
    apb_write(REG_TICK_RATE, ticks);
  endtask

  task automatic send_beat(input logic cmd, input logic [STAMP_BITS-1:0] ts);
    if (!quiet && $urandom_range(0, 9) < gap_odds) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    timestamp = ts;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly start-then-frames runs at a steady period, with some noise beats
  task automatic run_streams(input int unsigned beats);
    logic [STAMP_BITS-1:0] stamp;
    logic [STAMP_BITS-1:0] step;
    int unsigned           period;
    int unsigned           frames;
    int unsigned           sent;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'($urandom), rand_stamp());
        sent++;
        continue;
      end
      stamp = rand_stamp();
      send_beat(CMD_START, stamp);
      sent++;
      case ($urandom_range(0, 3))
        0: period = $urandom_range(1, 20);
        1: period = $urandom_range(1, 5000);
        2: period = $urandom_range(1, 1 << 20);
        default: period = $urandom;
      endcase
      frames = $urandom_range(1, 40);
      repeat (frames) begin
        case ($urandom_range(0, 19))
          0: step = '0;
          1: step = rand_stamp();
          2: step = STAMP_BITS'($urandom_range(1, 3));
          default: step = STAMP_BITS'(period) + STAMP_BITS'($urandom_range(0, period / 8));
        endcase
        stamp = stamp + step;
        send_beat(CMD_FRAME, stamp);
        sent++;
      end
    end
  endtask

  function automatic logic [WL_W-1:0] pick_window();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return WL_W'(1);
      2: return WL_W'(MAX_WINDOW);
      3: return '1;
      4: return WL_W'($urandom_range(MAX_WINDOW + 1, 126));
      default: return WL_W'($urandom_range(2, MAX_WINDOW - 1));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return RATE_W'(1);
      2: return '1;
      3: return TICK_RESET;
      default: return RATE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    command = CMD_START;
    timestamp = '0;
    quiet = 1'b0;
    gap_odds = 3;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: start, zero interval, partly filled window, wrap, huge interval
    send_beat(CMD_START, '0);
    send_beat(CMD_FRAME, '0);
    send_beat(CMD_FRAME, 48'd16);
    send_beat(CMD_FRAME, 48'd16);
    send_beat(CMD_FRAME, '1);
    send_beat(CMD_FRAME, 48'd9);
    send_beat(CMD_START, 48'hAAAA_AAAA_AAAA);
    send_beat(CMD_FRAME, 48'h5555_5555_5555);

    // one-slot window at the top tick rate: quotient saturates
    set_meter(WL_W'(1), '1);
    send_beat(CMD_START, '0);
    send_beat(CMD_FRAME, 48'd1);
    send_beat(CMD_FRAME, 48'h0000_FFFF_FFFF);

    // window length zero acts as one, tick rate zero gives a valid zero
    set_meter('0, '0);
    send_beat(CMD_FRAME, 48'h0001_0000_0004);
    send_beat(CMD_FRAME, 48'h0001_0000_0010);

    // window length above the maximum
    set_meter('1, TICK_RESET);
    send_beat(CMD_START, 48'h8000_0000_0000);
    for (int i = 1; i <= 5; i++) send_beat(CMD_FRAME, 48'h8000_0000_0000 + 48'(i * 17));

    set_meter(WL_W'(MAX_WINDOW), RATE_W'(1));
    send_beat(CMD_START, 48'd100);
    for (int i = 1; i <= 4; i++) send_beat(CMD_FRAME, 48'd100 + 48'(i * 3));

    for (int ph = 0; ph < 6; ph++) begin
      set_meter(pick_window(), pick_ticks());
      gap_odds = $urandom_range(0, 5);
      quiet = (ph == 5);
      run_streams(125);
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: moving_average_frame_rate_meter.f
+incdir+src
src/mafr_pkg.sv
src/mafr_front.sv
src/mafr_queue.sv
src/mafr_back.sv
src/moving_average_frame_rate_meter.sv
src/mafr_checker.sv
verif/frame_rate_checker.sv
verif/tb_moving_average_frame_rate_meter.sv
